### rtl/tsa_pkg.sv
package tsa_pkg;

   localparam int NUM_SLOTS = 4;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int TRACK_W   = 32;
   localparam int FRAME_W   = 32;
   localparam int MISS_W    = 8;
   localparam int SLOT_W    = 2;
   localparam int MASK_W    = 4;

   typedef logic [IDX_W-1:0] idx_type;

   // Victim search token passed along the row of slot cells
   typedef struct packed {
      logic                vld;
      logic                free;
      logic                have;
      idx_type             idx;
      logic [FRAME_W-1:0]  seen;
   } cand_type;

   // Command broadcast from the sequencer to every slot cell
   typedef struct packed {
      logic                age;
      logic                wr;
      idx_type             wr_idx;
      logic [TRACK_W-1:0]  track;
      logic [FRAME_W-1:0]  frame;
      logic [MISS_W-1:0]   gap;
   } cmd_type;

   function automatic logic [SLOT_W-1:0] to_slot(input idx_type idx);
      logic [IDX_W+SLOT_W-1:0] t;
      t = {{SLOT_W{1'b0}}, idx};
      return t[SLOT_W-1:0];
   endfunction

   function automatic logic [MASK_W-1:0] to_mask(input logic [NUM_SLOTS-1:0] v);
      logic [NUM_SLOTS+MASK_W-1:0] t;
      t = {{MASK_W{1'b0}}, v};
      return t[MASK_W-1:0];
   endfunction

endpackage

### rtl/track_slot_allocator.sv
// Track slot allocator: binds 32-bit track ids to a small row of slots and frees slots whose
// tracks stop appearing. An item is taken when start is high and busy low; its single result
// beat shows on the rsp_ ports for one cycle under rsp_strobe, in the cycle that busy falls,
// and cannot be held off. End-of-frame items and observe hits keep busy high in one state;
// an observe miss keeps it through the look state and the scan state, in which the victim
// search token walks the slot cells one per cycle. gap_tolerance resets to 5; the user must
// write it through csr_wr_en / csr_wr_data while no item is in flight; unchecked here.
module track_slot_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic [tsa_pkg::TRACK_W-1:0] req_track_id,
   input  logic [tsa_pkg::FRAME_W-1:0] req_frame_id,
   input  logic                        csr_wr_en,
   input  logic [tsa_pkg::MISS_W-1:0]  csr_wr_data,
   output logic                        rsp_strobe,
   output logic [tsa_pkg::SLOT_W-1:0]  rsp_slot_index,
   output logic                        rsp_hit,
   output logic                        rsp_replaced_active,
   output logic [tsa_pkg::MASK_W-1:0]  rsp_freed_mask
);
   import tsa_pkg::*;

   cmd_type              cmd;
   cand_type             chain [NUM_SLOTS+1];
   logic [NUM_SLOTS-1:0] match_vec;
   logic [NUM_SLOTS-1:0] free_vec;

   tsa_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_track_id        (req_track_id),
      .req_frame_id        (req_frame_id),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .cmd                 (cmd),
      .seed                (chain[0]),
      .cand_last           (chain[NUM_SLOTS]),
      .match_vec           (match_vec),
      .free_vec            (free_vec),
      .rsp_strobe          (rsp_strobe),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_hit             (rsp_hit),
      .rsp_replaced_active (rsp_replaced_active),
      .rsp_freed_mask      (rsp_freed_mask)
   );

   for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_cell
      tsa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(s)),
         .cmd       (cmd),
         .cand_prev (chain[s]),
         .cand_next (chain[s+1]),
         .match     (match_vec[s]),
         .free_now  (free_vec[s])
      );
   end

endmodule

### rtl/tsa_cell.sv
module tsa_cell (
   input  logic              clock,
   input  logic              reset,
   input  tsa_pkg::idx_type  cell_idx,
   input  tsa_pkg::cmd_type  cmd,
   input  tsa_pkg::cand_type cand_prev,
   output tsa_pkg::cand_type cand_next,
   output logic              match,
   output logic              free_now
);
   import tsa_pkg::*;

   logic               active_ff, active_in;
   logic [TRACK_W-1:0] track_ff, track_in;
   logic [FRAME_W-1:0] seen_ff, seen_in;
   logic [MISS_W-1:0]  missing_ff, missing_in;
   cand_type           cand_ff, cand_in;
   logic               stale;

   assign match     = active_ff && (track_ff == cmd.track);
   assign stale     = active_ff && (seen_ff != cmd.frame);
   assign free_now  = cmd.age && stale && (missing_ff >= cmd.gap);
   assign cand_next = cand_ff;

   always_comb begin
      active_in  = active_ff;
      track_in   = track_ff;
      seen_in    = seen_ff;
      missing_in = missing_ff;
      if (cmd.wr && (cmd.wr_idx == cell_idx)) begin
         active_in  = 1'b1;
         track_in   = cmd.track;
         seen_in    = cmd.frame;
         missing_in = '0;
      end else if (cmd.age && stale) begin
         if (missing_ff >= cmd.gap) begin
            active_in  = 1'b0;
            track_in   = '0;
            missing_in = '0;
         end else begin
            missing_in = missing_ff + MISS_W'(1);
         end
      end
   end

   // first free slot wins, else strictly older slot takes the token
   always_comb begin
      cand_in = cand_prev;
      if (cand_prev.vld && !cand_prev.free) begin
         if (!active_ff) begin
            cand_in.free = 1'b1;
            cand_in.idx  = cell_idx;
         end else if (!cand_prev.have || (seen_ff < cand_prev.seen)) begin
            cand_in.have = 1'b1;
            cand_in.idx  = cell_idx;
            cand_in.seen = seen_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         track_ff   <= '0;
         seen_ff    <= '0;
         missing_ff <= '0;
         cand_ff    <= '0;
      end else begin
         active_ff  <= active_in;
         track_ff   <= track_in;
         seen_ff    <= seen_in;
         missing_ff <= missing_in;
         cand_ff    <= cand_in;
      end
   end

endmodule

### rtl/tsa_ctrl.sv
module tsa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [tsa_pkg::TRACK_W-1:0]   req_track_id,
   input  logic [tsa_pkg::FRAME_W-1:0]   req_frame_id,
   input  logic                          csr_wr_en,
   input  logic [tsa_pkg::MISS_W-1:0]    csr_wr_data,
   output tsa_pkg::cmd_type              cmd,
   output tsa_pkg::cand_type             seed,
   input  tsa_pkg::cand_type             cand_last,
   input  logic [tsa_pkg::NUM_SLOTS-1:0] match_vec,
   input  logic [tsa_pkg::NUM_SLOTS-1:0] free_vec,
   output logic                          rsp_strobe,
   output logic [tsa_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic                          rsp_hit,
   output logic                          rsp_replaced_active,
   output logic [tsa_pkg::MASK_W-1:0]    rsp_freed_mask
);
   import tsa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_AGE  = 4'b0010,
      ST_LOOK = 4'b0100,
      ST_SCAN = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [TRACK_W-1:0] track_ff, track_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [MISS_W-1:0]  gap_ff;
   logic               strobe_ff, strobe_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               hit_ff, hit_in;
   logic               repl_ff, repl_in;
   logic [MASK_W-1:0]  freed_ff, freed_in;
   idx_type            hit_idx;

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_slot_index      = slot_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_replaced_active = repl_ff;
   assign rsp_freed_mask      = freed_ff;

   always_comb begin
      hit_idx = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (match_vec[s]) hit_idx = IDX_W'(s);
      end
   end

   always_comb begin
      state_in   = state_ff;
      track_in   = track_ff;
      frame_in   = frame_ff;
      strobe_in  = 1'b0;
      slot_in    = '0;
      hit_in     = 1'b0;
      repl_in    = 1'b0;
      freed_in   = '0;
      cmd        = '0;
      cmd.track  = track_ff;
      cmd.frame  = frame_ff;
      cmd.gap    = gap_ff;
      seed       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               track_in = req_track_id;
               frame_in = req_frame_id;
               state_in = req_op ? ST_AGE : ST_LOOK;
            end
         end
         ST_AGE: begin
            cmd.age   = 1'b1;
            strobe_in = 1'b1;
            freed_in  = to_mask(free_vec);
            state_in  = ST_IDLE;
         end
         ST_LOOK: begin
            if (|match_vec) begin
               cmd.wr     = 1'b1;
               cmd.wr_idx = hit_idx;
               strobe_in  = 1'b1;
               slot_in    = to_slot(hit_idx);
               hit_in     = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               seed.vld = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cand_last.vld) begin
               cmd.wr     = 1'b1;
               cmd.wr_idx = cand_last.idx;
               strobe_in  = 1'b1;
               slot_in    = to_slot(cand_last.idx);
               repl_in    = !cand_last.free;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         gap_ff    <= MISS_W'(5);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (csr_wr_en) gap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      track_ff <= track_in;
      frame_ff <= frame_in;
      slot_ff  <= slot_in;
      hit_ff   <= hit_in;
      repl_ff  <= repl_in;
      freed_ff <= freed_in;
   end

endmodule

### rtl/tsa_checker.sv
module tsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_op,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_slot_index,
   input logic        rsp_hit,
   input logic        rsp_replaced_active,
   input logic [3:0]  rsp_freed_mask
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   a_age_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op |=> ##1 rsp_strobe)
      else $error("end-of-frame result late");

   a_kind_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_freed_mask != 4'b0000) |->
         (rsp_slot_index == 2'b00) && !rsp_hit && !rsp_replaced_active)
      else $error("aging beat carries observe fields");

   a_hit_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_hit && rsp_replaced_active))
      else $error("hit and eviction in one beat");

endmodule

bind track_slot_allocator tsa_checker u_tsa_checker (.*);
